@@ hw/rtl/mglf_pkg.sv @@
// ---------------------------------------------------------------------------
// mglf_pkg: shared types and codes for the multicast group list filter
// Command, list and verdict codes, controller states and the command bundle
// that the controller sends to the datapath.
// ---------------------------------------------------------------------------
package mglf_pkg;

  localparam int NUM_LISTS = 3;

  typedef logic [1:0] cmd_code_t;
  localparam cmd_code_t CMD_LOOKUP = 2'd0;
  localparam cmd_code_t CMD_INSERT = 2'd1;
  localparam cmd_code_t CMD_REMOVE = 2'd2;
  localparam cmd_code_t CMD_FLUSH  = 2'd3;

  typedef logic [1:0] list_sel_t;
  localparam list_sel_t LIST_WHITE = 2'd0;
  localparam list_sel_t LIST_GREY  = 2'd1;
  localparam list_sel_t LIST_BLACK = 2'd2;

  typedef logic [1:0] verdict_t;
  localparam verdict_t VERDICT_DROP  = 2'd0;
  localparam verdict_t VERDICT_ASK   = 2'd1;
  localparam verdict_t VERDICT_ALLOW = 2'd2;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_LAST,
    ST_FINISH
  } ctrl_state_t;

  typedef struct packed {
    logic load;
    logic clear;
    logic scan;
    logic finish;
  } ctrl_cmd_t;

endpackage

@@ hw/rtl/mglf_list_mem.sv @@
// ---------------------------------------------------------------------------
// mglf_list_mem: storage for one address list
// Simple dual-port memory with one write port and one registered read port.
// ---------------------------------------------------------------------------
module mglf_list_mem #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 33,
  localparam int AddrW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AddrW-1:0] wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AddrW-1:0] rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem_r[rd_addr];
    end
  end

endmodule

@@ hw/rtl/mglf_datapath.sv @@
// ---------------------------------------------------------------------------
// mglf_datapath: list memories, address compare and verdict logic
// Scans the three lists in parallel, tracks hits and the first free slot of
// the selected list, applies remove, flush and insert, and forms the result.
// ---------------------------------------------------------------------------
module mglf_datapath #(
  parameter int LIST_DEPTH = 64,
  parameter int ADDR_BITS  = 32,
  localparam int IdxW = $clog2(LIST_DEPTH)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  mglf_pkg::ctrl_cmd_t cmd,
  input  logic [IdxW-1:0]     idx,
  input  logic [1:0]          in_cmd,
  input  logic [1:0]          in_list_select,
  input  logic [31:0]         in_group_address,
  output logic                out_valid,
  output logic [1:0]          out_verdict,
  output logic                out_status
);

  import mglf_pkg::*;

  localparam int KeyW  = (ADDR_BITS < 32) ? ADDR_BITS : 32;
  localparam int WordW = KeyW + 1;

  cmd_code_t            op_r;
  list_sel_t            sel_r;
  logic [KeyW-1:0]      key_r;
  logic                 rd_vld_r;
  logic [IdxW-1:0]      rd_idx_r;
  logic [NUM_LISTS-1:0] hit_r;
  logic                 free_found_r;
  logic [IdxW-1:0]      free_idx_r;
  logic                 out_valid_r;
  verdict_t             out_verdict_r;
  logic                 out_status_r;

  logic [NUM_LISTS-1:0] wr_en;
  logic [IdxW-1:0]      wr_addr [NUM_LISTS];
  logic [WordW-1:0]     wr_data [NUM_LISTS];
  logic [WordW-1:0]     rd_data [NUM_LISTS];
  logic [NUM_LISTS-1:0] match;
  logic [NUM_LISTS-1:0] sel_hit;
  logic [NUM_LISTS-1:0] hit_fin;
  logic                 sel_vbit;
  logic                 hit_sel;
  logic                 free_cand;
  verdict_t             verdict_nxt;
  logic                 status_nxt;

  for (genvar g = 0; g < NUM_LISTS; g++) begin : g_list
    mglf_list_mem #(
      .DEPTH(LIST_DEPTH),
      .WIDTH(WordW)
    ) u_mem (
      .clk    (clk),
      .wr_en  (wr_en[g]),
      .wr_addr(wr_addr[g]),
      .wr_data(wr_data[g]),
      .rd_en  (cmd.scan),
      .rd_addr(idx),
      .rd_data(rd_data[g])
    );
  end

  always_comb begin
    for (int l = 0; l < NUM_LISTS; l++) begin
      sel_hit[l] = (sel_r == 2'(l));
      match[l]   = rd_vld_r && rd_data[l][KeyW] && (rd_data[l][KeyW-1:0] == key_r);
      wr_en[l]   = 1'b0;
      wr_addr[l] = rd_idx_r;
      wr_data[l] = '0;
      if (cmd.clear) begin
        wr_en[l]   = 1'b1;
        wr_addr[l] = idx;
      end else if (rd_vld_r && sel_hit[l] &&
                   (((op_r == CMD_REMOVE) && match[l]) || (op_r == CMD_FLUSH))) begin
        wr_en[l] = 1'b1;
      end else if (cmd.finish && sel_hit[l] && (op_r == CMD_INSERT) &&
                   !hit_r[l] && free_found_r) begin
        wr_en[l]   = 1'b1;
        wr_addr[l] = free_idx_r;
        wr_data[l] = {1'b1, key_r};
      end
    end
  end

  always_comb begin
    case (sel_r)
      LIST_WHITE: begin
        sel_vbit = rd_data[LIST_WHITE][KeyW];
        hit_sel  = hit_r[LIST_WHITE];
      end
      LIST_GREY: begin
        sel_vbit = rd_data[LIST_GREY][KeyW];
        hit_sel  = hit_r[LIST_GREY];
      end
      LIST_BLACK: begin
        sel_vbit = rd_data[LIST_BLACK][KeyW];
        hit_sel  = hit_r[LIST_BLACK];
      end
      default: begin
        sel_vbit = 1'b1;
        hit_sel  = 1'b1;
      end
    endcase
    free_cand = rd_vld_r && !sel_vbit && !free_found_r;
  end

  always_comb begin
    for (int l = 0; l < NUM_LISTS; l++) begin
      hit_fin[l] = hit_r[l];
      if (sel_hit[l]) begin
        case (op_r)
          CMD_REMOVE: hit_fin[l] = 1'b0;
          CMD_FLUSH:  hit_fin[l] = 1'b0;
          CMD_INSERT: hit_fin[l] = hit_r[l] | free_found_r;
          default:    hit_fin[l] = hit_r[l];
        endcase
      end
    end
    if (hit_fin[LIST_BLACK]) begin
      verdict_nxt = VERDICT_DROP;
    end else if (hit_fin[LIST_GREY]) begin
      verdict_nxt = VERDICT_ASK;
    end else if (hit_fin[LIST_WHITE]) begin
      verdict_nxt = VERDICT_ALLOW;
    end else begin
      verdict_nxt = VERDICT_DROP;
    end
    status_nxt = (op_r == CMD_INSERT) && !hit_sel && !free_found_r;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= in_cmd;
      sel_r <= in_list_select;
      key_r <= in_group_address[KeyW-1:0];
    end
    if (cmd.scan) begin
      rd_idx_r <= idx;
    end
    if (cmd.load) begin
      hit_r        <= '0;
      free_found_r <= 1'b0;
    end else if (rd_vld_r) begin
      hit_r <= hit_r | match;
      if (free_cand) begin
        free_found_r <= 1'b1;
        free_idx_r   <= rd_idx_r;
      end
    end
    if (cmd.finish) begin
      out_verdict_r <= verdict_nxt;
      out_status_r  <= status_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      rd_vld_r    <= cmd.scan;
      out_valid_r <= cmd.finish;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_verdict = out_verdict_r;
  assign out_status  = out_status_r;

  a_result_after_finish: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(cmd.finish))
    else $error("Result strobe without a finished scan.");

  a_refusal_only_on_insert: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r) |-> (op_r == CMD_INSERT))
    else $error("Refusal flagged for a command other than insert.");

  a_no_result_after_load: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> !out_valid_r)
    else $error("Result strobe right after a new beat was taken.");

  a_insert_hit_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.finish && (op_r == CMD_INSERT) && !status_nxt && (sel_r != 2'd3)) |->
    ((hit_fin & sel_hit) != '0))
    else $error("Accepted insert leaves the address out of its list.");

endmodule

@@ hw/rtl/mglf_ctrl.sv @@
// ---------------------------------------------------------------------------
// mglf_ctrl: sequencer for the multicast group list filter
// Runs the clearing pass after reset, then one list scan per command beat,
// and drives the slot index and the datapath commands.
// ---------------------------------------------------------------------------
module mglf_ctrl #(
  parameter int LIST_DEPTH = 64,
  localparam int IdxW = $clog2(LIST_DEPTH)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  output mglf_pkg::ctrl_cmd_t cmd,
  output logic [IdxW-1:0]     idx
);

  import mglf_pkg::*;

  ctrl_state_t     state_r;
  ctrl_state_t     state_nxt;
  logic [IdxW-1:0] idx_r;
  logic [IdxW-1:0] idx_nxt;
  logic            last;

  assign last = (idx_r == IdxW'(LIST_DEPTH - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    case (state_r)
      ST_CLEAR: begin
        if (last) begin
          state_nxt = ST_IDLE;
          idx_nxt   = '0;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      ST_IDLE: begin
        idx_nxt = '0;
        if (start) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (last) begin
          state_nxt = ST_LAST;
          idx_nxt   = '0;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      ST_LAST: begin
        state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_CLEAR;
        idx_nxt   = '0;
      end
    endcase
  end

  always_comb begin
    busy       = (state_r != ST_IDLE);
    cmd.load   = (state_r == ST_IDLE) && start;
    cmd.clear  = (state_r == ST_CLEAR);
    cmd.scan   = (state_r == ST_SCAN);
    cmd.finish = (state_r == ST_FINISH);
    idx        = idx_r;
  end

endmodule

@@ hw/rtl/multicast_group_list_filter.sv @@
// ---------------------------------------------------------------------------
// multicast_group_list_filter: white, grey and black multicast group lists
// Looks up, inserts, removes or flushes group addresses and classifies the
// address against the lists as they stand after the command.
//
//   Channel   Ports                                      Handshake
//   input     in_cmd, in_list_select, in_group_address   start && !busy
//   result    out_verdict, out_status                    out_valid, one cycle
//
// A beat is taken only while idle, so a new one waits until the last is done;
// the scan reads one slot of each list memory per cycle.
// The result strobe rises after the scan, last and finish states, in the
// same cycle that busy drops.
// After reset a clearing pass over every slot holds busy high.
// The receiver cannot stall; each result is shown for exactly one cycle.
// ---------------------------------------------------------------------------
module multicast_group_list_filter #(
  parameter int LIST_DEPTH = 64,
  parameter int ADDR_BITS  = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_cmd,
  input  logic [1:0]  in_list_select,
  input  logic [31:0] in_group_address,
  output logic        out_valid,
  output logic [1:0]  out_verdict,
  output logic        out_status
);

  import mglf_pkg::*;

  localparam int IdxW = $clog2(LIST_DEPTH);

  ctrl_cmd_t       ctrl_cmd;
  logic [IdxW-1:0] slot_idx;

  mglf_ctrl #(
    .LIST_DEPTH(LIST_DEPTH)
  ) u_ctrl (
    .clk  (clk),
    .rst_n(rst_n),
    .start(start),
    .busy (busy),
    .cmd  (ctrl_cmd),
    .idx  (slot_idx)
  );

  mglf_datapath #(
    .LIST_DEPTH(LIST_DEPTH),
    .ADDR_BITS (ADDR_BITS)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (ctrl_cmd),
    .idx             (slot_idx),
    .in_cmd          (in_cmd),
    .in_list_select  (in_list_select),
    .in_group_address(in_group_address),
    .out_valid       (out_valid),
    .out_verdict     (out_verdict),
    .out_status      (out_status)
  );

endmodule
